@@ rtl/core/point_crop_box_nn_filter_defines.svh @@
// Assertion macros for the point crop-box filter.
`ifndef POINT_CROP_BOX_NN_FILTER_DEFINES_SVH
`define POINT_CROP_BOX_NN_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PCB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PCB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCB_ASSERT_IMP(name, ante, cons, msg)
`define PCB_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/core/pcb_pkg.sv @@
// Types and constants shared by the point crop-box filter files.
package pcb_pkg;

  localparam int COORD_W      = 32;
  localparam int COLOUR_W     = 24;
  localparam int FUNC_W       = 2;
  localparam int RADIUS_W     = 31;
  localparam int CAL_CAPACITY = 1024;
  localparam int CAL_AW       = (CAL_CAPACITY > 1) ? $clog2(CAL_CAPACITY) : 1;
  localparam int CNT_W        = $clog2(CAL_CAPACITY + 1);
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;
  localparam int REG_IDX_W    = 3;
  localparam int SQ_W         = 2 * COORD_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3277);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_CLEAR  = 2'd2
  } pcb_func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_LOWER = 3'd0,
    REG_X_UPPER = 3'd1,
    REG_Y_LOWER = 3'd2,
    REG_Y_UPPER = 3'd3,
    REG_Z_LOWER = 3'd4,
    REG_Z_UPPER = 3'd5,
    REG_NB_MODE = 3'd6,
    REG_RADIUS  = 3'd7
  } pcb_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RSQ,
    S_DIFF,
    S_SQY,
    S_SQZ,
    S_CMP,
    S_OUT
  } pcb_state_e;

endpackage

@@ rtl/core/pcb_ifs.sv @@
// Stream interfaces for input points and kept points.
interface pcb_point_if;
  import pcb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  logic                       coords_valid;
  logic [COLOUR_W-1:0]        colour;

  modport source (output valid, func, coord_x, coord_y, coord_z, coords_valid, colour,
                  input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, coords_valid, colour,
                  output ready);
endinterface

interface pcb_kept_if;
  import pcb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  kept_x;
  logic signed [COORD_W-1:0]  kept_y;
  logic signed [COORD_W-1:0]  kept_z;
  logic [COLOUR_W-1:0]        kept_colour;

  modport source (output valid, kept_x, kept_y, kept_z, kept_colour, input ready);
  modport sink   (input valid, kept_x, kept_y, kept_z, kept_colour, output ready);
endinterface

@@ rtl/core/point_crop_box_nn_filter.sv @@
// Top level of the point crop-box filter with calibration neighbour test.
//
//   channel   direction  handshake        payload
//   pts_i     in         valid / ready    func, coord_x/y/z, coords_valid, colour
//   kept_o    out        valid / ready    kept_x/y/z, kept_colour
//   apb       in         psel / penable   8 registers at byte address 4*i
//
// Appends, clears and rejected points pass through decode back to idle; a kept point without
// scan passes through the output state as well. A neighbour scan squares the radius, then for
// each entry visited forms the differences, squares Y, squares Z and compares, using the
// single 32 x 32 multiplier that squares each difference in turn.
// Reset is asynchronous; the calibration table needs no clearing pass.
// A kept point waits in the output register while the next item is accepted.
`include "point_crop_box_nn_filter_defines.svh"

module point_crop_box_nn_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pcb_point_if.sink                    pts_i,
  pcb_kept_if.source                   kept_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [pcb_pkg::APB_AW-1:0]   paddr_i,
  input  logic [pcb_pkg::APB_DW-1:0]   pwdata_i,
  output logic [pcb_pkg::APB_DW-1:0]   prdata_o,
  output logic                         pready_o
);
  import pcb_pkg::*;

  pcb_state_e state_q, state_d;

  logic signed [COORD_W-1:0] x_lower_q, x_upper_q, y_lower_q, y_upper_q;
  logic signed [COORD_W-1:0] z_lower_q, z_upper_q;
  logic                      nb_mode_q;
  logic [RADIUS_W-1:0]       radius_q;

  logic [FUNC_W-1:0]         func_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic                      vld_q;
  logic [COLOUR_W-1:0]       colour_q;

  logic [CNT_W-1:0]          cal_count_q, cal_count_d;
  logic [CAL_AW-1:0]         idx_q, idx_d;
  logic                      mem_we;

  logic signed [COORD_W-1:0] cal_y_mem [CAL_CAPACITY];
  logic signed [COORD_W-1:0] cal_z_mem [CAL_CAPACITY];
  logic signed [COORD_W-1:0] cal_y_rd_q, cal_z_rd_q;

  logic [COORD_W-1:0]        dy_q, dz_q, dy_d, dz_d;
  logic [COORD_W:0]          diff_y, diff_z;
  logic [COORD_W-1:0]        mul_a, mul_b;
  logic [SQ_W-1:0]           mul_p;
  logic [SQ_W-1:0]           r2_q, dy2_q, prod_q;
  logic [SQ_W:0]             dist_sum;
  logic                      hit;
  logic                      in_box;

  logic                      out_valid_q, out_valid_d, out_load;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [COLOUR_W-1:0]       out_colour_q;

  logic                      cfg_we;
  logic [REG_IDX_W-1:0]      cfg_idx;

  // Configuration port
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign cfg_idx  = paddr_i[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lower_q <= {1'b1, {(COORD_W-1){1'b0}}};
      x_upper_q <= {1'b0, {(COORD_W-1){1'b1}}};
      y_lower_q <= {1'b1, {(COORD_W-1){1'b0}}};
      y_upper_q <= {1'b0, {(COORD_W-1){1'b1}}};
      z_lower_q <= {1'b1, {(COORD_W-1){1'b0}}};
      z_upper_q <= {1'b0, {(COORD_W-1){1'b1}}};
      nb_mode_q <= 1'b0;
      radius_q  <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (pcb_reg_e'(cfg_idx))
        REG_X_LOWER: x_lower_q <= pwdata_i;
        REG_X_UPPER: x_upper_q <= pwdata_i;
        REG_Y_LOWER: y_lower_q <= pwdata_i;
        REG_Y_UPPER: y_upper_q <= pwdata_i;
        REG_Z_LOWER: z_lower_q <= pwdata_i;
        REG_Z_UPPER: z_upper_q <= pwdata_i;
        REG_NB_MODE: nb_mode_q <= pwdata_i[0];
        REG_RADIUS:  radius_q  <= pwdata_i[RADIUS_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (pcb_reg_e'(cfg_idx))
      REG_X_LOWER: prdata_o = x_lower_q;
      REG_X_UPPER: prdata_o = x_upper_q;
      REG_Y_LOWER: prdata_o = y_lower_q;
      REG_Y_UPPER: prdata_o = y_upper_q;
      REG_Z_LOWER: prdata_o = z_lower_q;
      REG_Z_UPPER: prdata_o = z_upper_q;
      REG_NB_MODE: prdata_o = {{(APB_DW-1){1'b0}}, nb_mode_q};
      REG_RADIUS:  prdata_o = {{(APB_DW-RADIUS_W){1'b0}}, radius_q};
      default:     prdata_o = '0;
    endcase
  end

  // Datapath helpers
  assign in_box = (x_q > x_lower_q) && (x_q < x_upper_q) &&
                  (y_q > y_lower_q) && (y_q < y_upper_q) &&
                  (z_q > z_lower_q) && (z_q < z_upper_q);

  assign diff_y = {y_q[COORD_W-1], y_q} - {cal_y_rd_q[COORD_W-1], cal_y_rd_q};
  assign diff_z = {z_q[COORD_W-1], z_q} - {cal_z_rd_q[COORD_W-1], cal_z_rd_q};
  assign dy_d   = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
  assign dz_d   = diff_z[COORD_W] ? COORD_W'(-diff_z) : diff_z[COORD_W-1:0];

  assign mul_p    = mul_a * mul_b;
  assign dist_sum = {1'b0, dy2_q} + {1'b0, prod_q};
  assign hit      = dist_sum < {1'b0, r2_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cal_count_d = cal_count_q;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    mul_a       = dy_q;
    mul_b       = dy_q;
    pts_i.ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        pts_i.ready = 1'b1;
        if (pts_i.valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (func_q)
          FUNC_APPEND: begin
            if (cal_count_q < CNT_W'(CAL_CAPACITY)) begin
              mem_we      = 1'b1;
              cal_count_d = cal_count_q + CNT_W'(1);
            end
          end
          FUNC_CLEAR: begin
            cal_count_d = '0;
          end
          FUNC_FILTER: begin
            idx_d = '0;
            if (vld_q && in_box) begin
              if (!nb_mode_q || (cal_count_q == '0)) begin
                state_d = S_OUT;
              end else begin
                state_d = S_RSQ;
              end
            end
          end
          default: ;
        endcase
      end
      S_RSQ: begin
        mul_a   = COORD_W'(radius_q);
        mul_b   = COORD_W'(radius_q);
        state_d = S_DIFF;
      end
      S_DIFF: begin
        state_d = S_SQY;
      end
      S_SQY: begin
        state_d = S_SQZ;
      end
      S_SQZ: begin
        mul_a   = dz_q;
        mul_b   = dz_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          state_d = S_OUT;
        end else if (CNT_W'(idx_q) + CNT_W'(1) == cal_count_q) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + CAL_AW'(1);
          state_d = S_DIFF;
        end
      end
      S_OUT: begin
        if (!out_valid_q || kept_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~kept_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cal_count_q <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_count_q <= cal_count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Calibration table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cal_y_mem[cal_count_q[CAL_AW-1:0]] <= y_q;
      cal_z_mem[cal_count_q[CAL_AW-1:0]] <= z_q;
    end
    cal_y_rd_q <= cal_y_mem[idx_d];
    cal_z_rd_q <= cal_z_mem[idx_d];
  end

  // Item, arithmetic and output registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && pts_i.valid) begin
      func_q   <= pts_i.func;
      x_q      <= pts_i.coord_x;
      y_q      <= pts_i.coord_y;
      z_q      <= pts_i.coord_z;
      vld_q    <= pts_i.coords_valid;
      colour_q <= pts_i.colour;
    end
    if (state_q == S_RSQ) begin
      r2_q <= mul_p;
    end
    if (state_q == S_DIFF) begin
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
    if (state_q == S_SQY) begin
      dy2_q <= mul_p;
    end
    if (state_q == S_SQZ) begin
      prod_q <= mul_p;
    end
    if (out_load) begin
      out_x_q      <= x_q;
      out_y_q      <= y_q;
      out_z_q      <= z_q;
      out_colour_q <= colour_q;
    end
  end

  assign kept_o.valid       = out_valid_q;
  assign kept_o.kept_x      = out_x_q;
  assign kept_o.kept_y      = out_y_q;
  assign kept_o.kept_z      = out_z_q;
  assign kept_o.kept_colour = out_colour_q;

  `PCB_ASSERT_IMP(a_count_bound, 1'b1, cal_count_q <= CNT_W'(CAL_CAPACITY), "Count too big.")
  `PCB_ASSERT_IMP(a_scan_index, state_q == S_CMP, CNT_W'(idx_q) < cal_count_q, "Bad index.")
  `PCB_ASSERT_NXT(a_out_source, (state_q != S_OUT) && !out_valid_q, !out_valid_q, "Bad result.")

endmodule

@@ tb/tb_point_crop_box_nn_filter.sv @@
// Self-checking testbench for the point crop-box filter with calibration neighbour test.
module tb_point_crop_box_nn_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import pcb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int Q16_ONE         = 65536;
  localparam int INT_LO          = 32'sh8000_0000;
  localparam int INT_HI          = 32'sh7FFF_FFFF;
  localparam int RAD_DEF         = int'(RADIUS_RESET);
  localparam int SETTLE_CYCLES   = 4200;
  localparam int QUIET_LIMIT     = 25000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int CAL_SOFT_CAP    = 48;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      cv;
    logic [COLOUR_W-1:0]       colour;
  } point_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [COLOUR_W-1:0]       colour;
  } kept_point_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pcb_point_if pts();
  pcb_kept_if  kept();

  point_crop_box_nn_filter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pts_i    (pts),
    .kept_o   (kept),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .pready_o (pready)
  );

  point_item_t pending_pts[$];
  kept_point_t kept_expected[$];
  int unsigned n_sent;
  int unsigned n_acc;
  int          mismatches;
  int          send_gap_pct;
  int          stall_pct;
  int          quiet_cycles;

  int                  box_lo[3];
  int                  box_hi[3];
  logic                nb_on;
  logic [RADIUS_W-1:0] radius;
  int                  calib_y[CAL_CAPACITY];
  int                  calib_z[CAL_CAPACITY];
  int                  calib_count;

  int gen_cal_y[$];
  int gen_cal_z[$];

  always #4 clk_i = ~clk_i;

  function automatic bit in_reach(int py, int pz, int cy, int cz);
    longint unsigned r2, dy, dz, dy2, dz2;
    longint d;
    r2 = longint'(radius) * longint'(radius);
    d = longint'(py) - longint'(cy);
    dy = (d < 0) ? -d : d;
    d = longint'(pz) - longint'(cz);
    dz = (d < 0) ? -d : d;
    dy2 = dy * dy;
    dz2 = dz * dz;
    return (dy2 < r2) && (dz2 < r2 - dy2);
  endfunction

  function automatic bit point_kept(point_item_t it);
    if (!it.cv) return 1'b0;
    if (!(it.x > box_lo[0] && it.x < box_hi[0] && it.y > box_lo[1] && it.y < box_hi[1] &&
          it.z > box_lo[2] && it.z < box_hi[2])) return 1'b0;
    if (nb_on && calib_count > 0) begin
      for (int i = 0; i < calib_count; i++) begin
        if (in_reach(it.y, it.z, calib_y[i], calib_z[i])) return 1'b1;
      end
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_item(point_item_t it);
    kept_point_t kp;
    case (it.func)
      FUNC_APPEND: begin
        if (calib_count < CAL_CAPACITY) begin
          calib_y[calib_count] = it.y;
          calib_z[calib_count] = it.z;
          calib_count++;
        end
      end
      FUNC_CLEAR: calib_count = 0;
      FUNC_FILTER: begin
        if (point_kept(it)) begin
          kp.x = it.x;
          kp.y = it.y;
          kp.z = it.z;
          kp.colour = it.colour;
          kept_expected = {kept_expected, kp};
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    point_item_t got_pt;
    kept_point_t want_pt;
    bit          busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (pts.valid && pts.ready) begin
        got_pt.func = pts.func;
        got_pt.x = pts.coord_x;
        got_pt.y = pts.coord_y;
        got_pt.z = pts.coord_z;
        got_pt.cv = pts.coords_valid;
        got_pt.colour = pts.colour;
        absorb_item(got_pt);
        n_acc++;
        busy = 1'b1;
      end
      if (kept.valid && kept.ready) begin
        busy = 1'b1;
        if (kept_expected.size() == 0) begin
          $error("Unexpected kept item: x 0x%08h, y 0x%08h, z 0x%08h, colour 0x%06h",
                 kept.kept_x, kept.kept_y, kept.kept_z, kept.kept_colour);
          mismatches++;
        end else begin
          want_pt = kept_expected.pop_front();
          check_field("kept_x", want_pt.x, kept.kept_x);
          check_field("kept_y", want_pt.y, kept.kept_y);
          check_field("kept_z", want_pt.z, kept.kept_z);
          check_field("kept_colour", want_pt.colour, kept.kept_colour);
        end
      end
      if (psel && penable && pready) busy = 1'b1;
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    point_item_t nxt;
    if (rst_ni && n_acc == n_sent) begin
      if (pending_pts.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt = pending_pts.pop_front();
        pts.func <= nxt.func;
        pts.coord_x <= nxt.x;
        pts.coord_y <= nxt.y;
        pts.coord_z <= nxt.z;
        pts.coords_valid <= nxt.cv;
        pts.colour <= nxt.colour;
        pts.valid <= 1'b1;
        n_sent++;
      end else begin
        pts.valid <= 1'b0;
      end
    end
    kept.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic point_item_t mk_item(logic [FUNC_W-1:0] f, int x, int y, int z, bit cv,
                                          int colour);
    point_item_t it;
    it.func = f;
    it.x = x;
    it.y = y;
    it.z = z;
    it.cv = cv;
    it.colour = colour[COLOUR_W-1:0];
    return it;
  endfunction

  task automatic queue_point(point_item_t it);
    pending_pts = {pending_pts, it};
  endtask

  function automatic int clamp32(longint v);
    if (v > INT_HI) return INT_HI;
    if (v < INT_LO) return INT_LO;
    return int'(v);
  endfunction

  function automatic int pick_coord(int lo, int hi);
    longint a, b;
    int     off;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(0, 9))
      0: return int'($urandom);
      1: begin
        off = $urandom_range(0, 3);
        return clamp32((off < 2) ? longint'(lo) + off : longint'(hi) - (off - 2));
      end
      default: return int'(a + longint'({$urandom, $urandom} % (b - a + 1)));
    endcase
  endfunction

  function automatic int near_coord(int c);
    longint r;
    r = longint'(radius);
    return clamp32(longint'(c) + longint'({$urandom, $urandom} % (2 * r + 3)) - (r + 1));
  endfunction

  task automatic write_reg(pcb_reg_e idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_X_LOWER: box_lo[0] = value;
      REG_X_UPPER: box_hi[0] = value;
      REG_Y_LOWER: box_lo[1] = value;
      REG_Y_UPPER: box_hi[1] = value;
      REG_Z_LOWER: box_lo[2] = value;
      REG_Z_UPPER: box_hi[2] = value;
      REG_NB_MODE: nb_on = value[0];
      REG_RADIUS:  radius = value[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_box(int xl, int xu, int yl, int yu, int zl, int zu);
    write_reg(REG_X_LOWER, xl);
    write_reg(REG_X_UPPER, xu);
    write_reg(REG_Y_LOWER, yl);
    write_reg(REG_Y_UPPER, yu);
    write_reg(REG_Z_LOWER, zl);
    write_reg(REG_Z_UPPER, zu);
  endtask

  task automatic write_random_box();
    int lo[3], hi[3];
    int cc, hw;
    for (int a = 0; a < 3; a++) begin
      cc = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      hw = $urandom_range(32'h0000_4000, 32'h0040_0000);
      lo[a] = cc - hw;
      hi[a] = cc + hw;
    end
    write_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  task automatic write_nn(bit mode, int r);
    write_reg(REG_NB_MODE, mode);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic set_idle(int gap, int stall);
    send_gap_pct = gap;
    stall_pct = stall;
  endtask

  task automatic quiesce();
    while (pending_pts.size() != 0 || n_acc != n_sent || kept_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic gen_phase(int n);
    int roll, k, y, z;
    queue_point(mk_item(FUNC_CLEAR, 0, 0, 0, 1'b1, 0));
    gen_cal_y.delete();
    gen_cal_z.delete();
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        queue_point(mk_item(FUNC_UNUSED, $urandom, $urandom, $urandom,
                            $urandom_range(0, 1), $urandom));
      end else if (roll < 8 || (roll < 35 && gen_cal_y.size() >= CAL_SOFT_CAP)) begin
        queue_point(mk_item(FUNC_CLEAR, $urandom, $urandom, $urandom,
                            $urandom_range(0, 1), $urandom));
        gen_cal_y.delete();
        gen_cal_z.delete();
      end else if (roll < 35) begin
        if (gen_cal_y.size() != 0 && $urandom_range(0, 2) == 0) begin
          k = $urandom_range(0, gen_cal_y.size() - 1);
          y = near_coord(gen_cal_y[k]);
          z = near_coord(gen_cal_z[k]);
        end else begin
          y = pick_coord(box_lo[1], box_hi[1]);
          z = pick_coord(box_lo[2], box_hi[2]);
        end
        queue_point(mk_item(FUNC_APPEND, $urandom, y, z, $urandom_range(0, 1), $urandom));
        gen_cal_y = {gen_cal_y, y};
        gen_cal_z = {gen_cal_z, z};
      end else begin
        if (gen_cal_y.size() != 0 && $urandom_range(0, 4) < 3) begin
          k = $urandom_range(0, gen_cal_y.size() - 1);
          y = near_coord(gen_cal_y[k]);
          z = near_coord(gen_cal_z[k]);
        end else begin
          y = pick_coord(box_lo[1], box_hi[1]);
          z = pick_coord(box_lo[2], box_hi[2]);
        end
        queue_point(mk_item(FUNC_FILTER, pick_coord(box_lo[0], box_hi[0]), y, z,
                            $urandom_range(0, 15) != 0, $urandom));
      end
    end
  endtask

  initial begin : stimulus
    pts.valid = 1'b0;
    pts.func = FUNC_FILTER;
    pts.coord_x = '0;
    pts.coord_y = '0;
    pts.coord_z = '0;
    pts.coords_valid = 1'b0;
    pts.colour = '0;
    kept.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_sent = 0;
    n_acc = 0;
    mismatches = 0;
    quiet_cycles = 0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = INT_LO;
      box_hi[a] = INT_HI;
    end
    nb_on = 1'b0;
    radius = RADIUS_RESET;
    calib_count = 0;
    set_idle(0, 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Settings after reset: box edges, invalid points, the unused selector, append and clear.
    queue_point(mk_item(FUNC_FILTER, INT_LO, 0, 0, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, INT_HI, 0, 0, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, 0, INT_LO, 0, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, 0, INT_HI, 0, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, 0, 0, INT_LO, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, 0, 0, INT_HI, 1'b1, 24'h123456));
    queue_point(mk_item(FUNC_FILTER, INT_LO + 1, INT_HI - 1, INT_LO + 1, 1'b1, 24'hFFFFFF));
    queue_point(mk_item(FUNC_FILTER, INT_HI - 1, INT_LO + 1, INT_HI - 1, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b0, 24'hABCDEF));
    queue_point(mk_item(FUNC_UNUSED, 5, 5, 5, 1'b1, 24'h555555));
    queue_point(mk_item(FUNC_APPEND, 0, Q16_ONE, Q16_ONE, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 7 * Q16_ONE, -7 * Q16_ONE, 3 * Q16_ONE, 1'b1,
                        24'h00FF00));
    queue_point(mk_item(FUNC_CLEAR, 0, 0, 0, 1'b1, 0));

    // Ten-metre box with the neighbour test on and the default radius.
    quiesce();
    write_box(-10 * Q16_ONE, 10 * Q16_ONE, -10 * Q16_ONE, 10 * Q16_ONE,
              -10 * Q16_ONE, 10 * Q16_ONE);
    write_nn(1'b1, RAD_DEF);
    set_idle(15, 15);
    queue_point(mk_item(FUNC_FILTER, 0, 9 * Q16_ONE, -9 * Q16_ONE, 1'b1, 24'h010203));
    queue_point(mk_item(FUNC_FILTER, 10 * Q16_ONE, 0, 0, 1'b1, 1));
    queue_point(mk_item(FUNC_FILTER, 10 * Q16_ONE - 1, 0, 0, 1'b1, 2));
    queue_point(mk_item(FUNC_FILTER, 0, -10 * Q16_ONE, 0, 1'b1, 3));
    queue_point(mk_item(FUNC_FILTER, 0, 0, -10 * Q16_ONE + 1, 1'b1, 4));
    queue_point(mk_item(FUNC_APPEND, INT_HI, Q16_ONE, 2 * Q16_ONE, 1'b0, 24'hFFFFFF));
    queue_point(mk_item(FUNC_APPEND, 0, -3 * Q16_ONE, 0, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 0, Q16_ONE + RAD_DEF, 2 * Q16_ONE, 1'b1, 5));
    queue_point(mk_item(FUNC_FILTER, 0, Q16_ONE + RAD_DEF - 1, 2 * Q16_ONE, 1'b1, 6));
    // Just inside and just outside the radius on the diagonal.
    queue_point(mk_item(FUNC_FILTER, 0, Q16_ONE + 2317, 2 * Q16_ONE - 2317, 1'b1, 7));
    queue_point(mk_item(FUNC_FILTER, 0, Q16_ONE - 2318, 2 * Q16_ONE + 2318, 1'b1, 8));
    queue_point(mk_item(FUNC_FILTER, 5, -3 * Q16_ONE - 100, 50, 1'b1, 9));
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b1, 10));
    queue_point(mk_item(FUNC_CLEAR, 0, 0, 0, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b1, 11));

    // Zero radius, then a box whose lower X bound admits nothing.
    quiesce();
    write_reg(REG_RADIUS, 0);
    set_idle(0, 0);
    queue_point(mk_item(FUNC_APPEND, 0, 0, 0, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b1, 12));
    queue_point(mk_item(FUNC_FILTER, 0, 1, 0, 1'b1, 13));
    queue_point(mk_item(FUNC_CLEAR, 0, 0, 0, 1'b1, 0));
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b1, 14));
    quiesce();
    write_reg(REG_X_LOWER, INT_HI);
    queue_point(mk_item(FUNC_FILTER, 0, 0, 0, 1'b1, 15));
    queue_point(mk_item(FUNC_FILTER, INT_HI - 1, 0, 0, 1'b1, 16));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiesce();
      case (p)
        0: begin
          write_random_box();
          write_nn(1'b1, $urandom_range(1, 32'h0004_0000));
          set_idle(0, 0);
        end
        1: begin
          write_box(INT_LO, INT_HI, INT_LO, INT_HI, INT_LO, INT_HI);
          write_nn(1'b1, INT_HI);
          set_idle(46, 0);
        end
        2: begin
          write_random_box();
          write_nn(1'b0, $urandom_range(1, 32'h0004_0000));
          set_idle(0, 46);
        end
        3: begin
          write_random_box();
          write_nn(1'b1, $urandom_range(1, 32'h0004_0000));
          set_idle(15, 15);
        end
        4: begin
          write_random_box();
          write_nn(1'b1, $urandom_range(1, 32'h0000_1000));
          set_idle(46, 0);
        end
        default: begin
          write_random_box();
          write_nn(1'b1, $urandom_range(1, 32'h0010_0000));
          set_idle(0, 46);
        end
      endcase
      gen_phase(ITEMS_PER_PHASE);
    end

    quiesce();
    if (mismatches == 0 && kept_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ point_crop_box_nn_filter.f @@
+incdir+rtl/core
rtl/core/pcb_pkg.sv
rtl/core/pcb_ifs.sv
rtl/core/point_crop_box_nn_filter.sv
tb/tb_point_crop_box_nn_filter.sv
